>>> rtl/core/csf_pkg.sv
// Shared types and constants of the current sense filter.
// Item structs, lane and merge control groups, sequencer states, register map.
// No dependencies.
package csf_pkg;

    localparam int CHANNELS      = 4;
    localparam int SAMPLE_BITS   = 12;
    localparam int CAL_SAMPLES   = 200;
    localparam int CAL_CNT_BITS  = 8;
    localparam int SUM_BITS      = 20;
    localparam int Q_FRAC        = 8;
    localparam int FILT_BITS     = SAMPLE_BITS + Q_FRAC;
    localparam int ALPHA_BITS    = 16;
    localparam int ALPHA_FRAC    = 16;
    localparam int GAIN_BITS     = 24;
    localparam int GAIN_SHIFT    = 24;
    localparam int OUT_BITS      = 18;
    localparam int MA_SUM_BITS   = OUT_BITS + $clog2(CHANNELS);
    localparam int POWER_BITS    = 38;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA         = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURRENT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOLTAGE_GAIN  = 2'd2;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd13107;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 24'd65536;
    localparam logic [OUT_BITS-1:0]   OUT_MAX     = {OUT_BITS{1'b1}};

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] coil_sample_0;
        logic [SAMPLE_BITS-1:0] coil_sample_1;
        logic [SAMPLE_BITS-1:0] coil_sample_2;
        logic [SAMPLE_BITS-1:0] coil_sample_3;
        logic [SAMPLE_BITS-1:0] bus_sample;
    } csf_scan_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]   current_ma_0;
        logic [OUT_BITS-1:0]   current_ma_1;
        logic [OUT_BITS-1:0]   current_ma_2;
        logic [OUT_BITS-1:0]   current_ma_3;
        logic [OUT_BITS-1:0]   bus_mv;
        logic [POWER_BITS-1:0] power_uw;
        logic                  cal_busy;
    } csf_result_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic mult;
        logic accum;
        logic scale;
        logic upd;
        logic acc;
        logic latch;
    } csf_lane_ctrl_t;

    typedef struct packed {
        logic capture;
        logic emit;
    } csf_merge_ctrl_t;

    typedef enum logic [2:0] {
        CSF_IDLE,
        CSF_PREP,
        CSF_MULT,
        CSF_ACCUM,
        CSF_SCALE,
        CSF_MERGE,
        CSF_OUTPUT
    } csf_state_t;

endpackage

>>> rtl/core/csf_lane.sv
// One channel lane: offset calibration, Q8 single-pole IIR and gain scaling.
// Uses csf_pkg; sequenced by csf_ctrl through a csf_lane_ctrl_t group.
module csf_lane #(
    parameter int CAL_SAMPLES = csf_pkg::CAL_SAMPLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csf_pkg::csf_lane_ctrl_t             ctrl,
    input  logic [csf_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic [csf_pkg::ALPHA_BITS-1:0]      alpha,
    input  logic [csf_pkg::GAIN_BITS-1:0]       gain,
    output logic [csf_pkg::OUT_BITS-1:0]        scaled
);

    localparam int SB        = csf_pkg::SAMPLE_BITS;
    localparam int FB        = csf_pkg::FILT_BITS;
    localparam int SUMB      = csf_pkg::SUM_BITS;
    localparam int PROD_BITS = FB + 1 + csf_pkg::ALPHA_BITS + 1;
    localparam int SCALE_BITS = FB + csf_pkg::GAIN_BITS;
    // floor(sum / CAL_SAMPLES) as a multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = SUMB + $clog2(CAL_SAMPLES);
    localparam int QUOT_BITS = SUMB + DIV_SHIFT + 1;
    localparam logic [DIV_SHIFT:0] DIV_MULT =
        (DIV_SHIFT + 1)'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1)
                         / 64'(CAL_SAMPLES));

    logic [SB-1:0]                sample_reg, sample_next;
    logic [SB-1:0]                offset_reg, offset_next;
    logic [SUMB-1:0]              sum_reg, sum_next;
    logic [FB-1:0]                y_reg, y_next;
    logic signed [FB:0]           diff_reg, diff_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [QUOT_BITS-1:0]         quot_reg, quot_next;
    logic [SCALE_BITS-1:0]        scale_reg, scale_next;

    logic [SB-1:0]                above;
    logic [FB-1:0]                target;
    logic signed [PROD_BITS-1:0]  step;

    always_comb
    begin
        above  = (sample_reg > offset_reg) ? sample_reg - offset_reg : '0;
        target = {above, {csf_pkg::Q_FRAC{1'b0}}};
        // arithmetic shift rounds the step toward minus infinity
        step   = prod_reg >>> csf_pkg::ALPHA_FRAC;

        sample_next = ctrl.load ? sample : sample_reg;
        offset_next = offset_reg;
        sum_next    = sum_reg;
        y_next      = y_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        quot_next   = quot_reg;
        scale_next  = scale_reg;

        if (ctrl.prep && ctrl.upd)
        begin
            diff_next = $signed({1'b0, target}) - $signed({1'b0, y_reg});
        end
        if (ctrl.prep && ctrl.acc)
        begin
            sum_next = sum_reg + SUMB'(sample_reg);
        end
        if (ctrl.mult && ctrl.upd)
        begin
            prod_next = diff_reg * $signed({1'b0, alpha});
        end
        if (ctrl.mult && ctrl.latch)
        begin
            quot_next = QUOT_BITS'(sum_reg) * QUOT_BITS'(DIV_MULT);
        end
        if (ctrl.accum && ctrl.upd)
        begin
            y_next = y_reg + step[FB-1:0];
        end
        if (ctrl.accum && ctrl.latch)
        begin
            offset_next = quot_reg[DIV_SHIFT +: SB];
            sum_next    = '0;
        end
        if (ctrl.scale)
        begin
            scale_next = SCALE_BITS'(y_reg) * SCALE_BITS'(gain);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            sum_reg    <= '0;
            y_reg      <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            sum_reg    <= sum_next;
            y_reg      <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        quot_reg   <= quot_next;
        scale_reg  <= scale_next;
    end

    always_comb
    begin
        if (|scale_reg[SCALE_BITS-1 : csf_pkg::GAIN_SHIFT + csf_pkg::OUT_BITS])
        begin
            scaled = csf_pkg::OUT_MAX;
        end
        else
        begin
            scaled = scale_reg[csf_pkg::GAIN_SHIFT +: csf_pkg::OUT_BITS];
        end
    end

endmodule

>>> rtl/core/csf_ctrl.sv
// Sequencer of the current sense filter and the calibration scan counter.
// Uses csf_pkg; drives the lanes and the merge stage.
module csf_ctrl #(
    parameter int CAL_SAMPLES = csf_pkg::CAL_SAMPLES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      scan_valid,
    input  logic                      mode,
    input  logic                      out_free,
    output logic                      scan_ready,
    output csf_pkg::csf_lane_ctrl_t   coil_ctrl,
    output csf_pkg::csf_lane_ctrl_t   bus_ctrl,
    output csf_pkg::csf_merge_ctrl_t  merge_ctrl,
    output logic                      cal_busy
);

    localparam int CB = csf_pkg::CAL_CNT_BITS;

    csf_pkg::csf_state_t state_reg, state_next;
    logic [CB-1:0]       count_reg, count_next;
    logic                mode_reg, mode_next;
    logic                latch_reg, latch_next;
    logic [CB-1:0]       count_inc;
    logic                accept;

    assign accept    = (state_reg == csf_pkg::CSF_IDLE) && scan_valid;
    assign count_inc = count_reg + CB'(1);
    assign cal_busy  = (count_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csf_pkg::CSF_IDLE:   if (scan_valid) state_next = csf_pkg::CSF_PREP;
            csf_pkg::CSF_PREP:   state_next = csf_pkg::CSF_MULT;
            csf_pkg::CSF_MULT:   state_next = csf_pkg::CSF_ACCUM;
            csf_pkg::CSF_ACCUM:  state_next = csf_pkg::CSF_SCALE;
            csf_pkg::CSF_SCALE:  state_next = csf_pkg::CSF_MERGE;
            csf_pkg::CSF_MERGE:  state_next = csf_pkg::CSF_OUTPUT;
            csf_pkg::CSF_OUTPUT: if (out_free) state_next = csf_pkg::CSF_IDLE;
            default:             state_next = csf_pkg::CSF_IDLE;
        endcase
    end

    always_comb
    begin
        scan_ready         = 1'b0;
        coil_ctrl          = '0;
        merge_ctrl         = '0;
        unique case (state_reg)
            csf_pkg::CSF_IDLE:
            begin
                scan_ready     = 1'b1;
                coil_ctrl.load = scan_valid;
            end
            csf_pkg::CSF_PREP:   coil_ctrl.prep  = 1'b1;
            csf_pkg::CSF_MULT:   coil_ctrl.mult  = 1'b1;
            csf_pkg::CSF_ACCUM:  coil_ctrl.accum = 1'b1;
            csf_pkg::CSF_SCALE:  coil_ctrl.scale = 1'b1;
            csf_pkg::CSF_MERGE:  merge_ctrl.capture = 1'b1;
            csf_pkg::CSF_OUTPUT: merge_ctrl.emit = out_free;
            default:             scan_ready = 1'b0;
        endcase
        coil_ctrl.upd   = !mode_reg;
        coil_ctrl.acc   = mode_reg;
        coil_ctrl.latch = latch_reg;
        // bus lane never calibrates, so its offset stays at zero
        bus_ctrl        = coil_ctrl;
        bus_ctrl.acc    = 1'b0;
        bus_ctrl.latch  = 1'b0;
    end

    always_comb
    begin
        count_next = count_reg;
        mode_next  = mode_reg;
        latch_next = latch_reg;
        if (accept)
        begin
            mode_next  = mode;
            latch_next = 1'b0;
            if (mode)
            begin
                if (count_inc >= CB'(CAL_SAMPLES))
                begin
                    count_next = '0;
                    latch_next = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csf_pkg::CSF_IDLE;
            count_reg <= '0;
            mode_reg  <= 1'b0;
            latch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
            latch_reg <= latch_next;
        end
    end

endmodule

>>> rtl/core/csf_merge.sv
// Merge stage: gathers the lane results, forms power and holds the result item.
// Uses csf_pkg; controlled by csf_ctrl.
module csf_merge (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  csf_pkg::csf_merge_ctrl_t                           ctrl,
    input  logic [csf_pkg::CHANNELS-1:0][csf_pkg::OUT_BITS-1:0] coil_ma,
    input  logic [csf_pkg::OUT_BITS-1:0]                       bus_mv,
    input  logic                                               cal_busy,
    input  logic                                               result_ready,
    output logic                                               result_valid,
    output csf_pkg::csf_result_t                               result
);

    localparam int OB = csf_pkg::OUT_BITS;
    localparam int PB = csf_pkg::POWER_BITS;
    localparam int MB = csf_pkg::MA_SUM_BITS;

    logic [csf_pkg::CHANNELS-1:0][OB-1:0] ma_reg;
    logic [OB-1:0]                        bus_reg;
    logic [MB-1:0]                        sum_reg, sum_next;
    logic                                 valid_reg, valid_next;
    csf_pkg::csf_result_t                 result_reg, result_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < csf_pkg::CHANNELS; i++)
        begin
            sum_next = sum_next + MB'(coil_ma[i]);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (ctrl.emit)
        begin
            result_next.current_ma_0 = ma_reg[0];
            result_next.current_ma_1 = ma_reg[1];
            result_next.current_ma_2 = ma_reg[2];
            result_next.current_ma_3 = ma_reg[3];
            result_next.bus_mv       = bus_reg;
            // 18 x 20 bits fits the 38-bit field, so no saturation is needed
            result_next.power_uw     = PB'(bus_reg) * PB'(sum_reg);
            result_next.cal_busy     = cal_busy;
        end
        valid_next = ctrl.emit ? 1'b1 : (result_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            ma_reg  <= coil_ma;
            bus_reg <= bus_mv;
            sum_reg <= sum_next;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/current_sense_filter.sv
// Offset-calibrated current and bus voltage monitor. Each scan item runs through
// four coil lanes and one bus lane side by side, then a merge stage that forms
// power; the block takes one scan at a time and a scan steps through accept,
// difference, multiply, accumulate, scale, merge and output, holding at output
// only while a finished result waits for result_ready. A new scan is
// taken in the cycle after its result is loaded, even if that result is still
// waiting. Calibration scans add into coil lane sums; every CAL_SAMPLES-th
// one latches the averages as zero offsets. Configuration writes are taken at any
// time and must only be issued while the block is idle. No memory clearing is
// needed after reset.
module current_sense_filter #(
    parameter int CAL_SAMPLES = csf_pkg::CAL_SAMPLES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 scan_valid,
    output logic                                 scan_ready,
    input  csf_pkg::csf_scan_t                   scan,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output csf_pkg::csf_result_t                 result,
    input  logic                                 cfg_we,
    input  logic [csf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [csf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic [csf_pkg::ALPHA_BITS-1:0] alpha_reg, alpha_next;
    logic [csf_pkg::GAIN_BITS-1:0]  cgain_reg, cgain_next;
    logic [csf_pkg::GAIN_BITS-1:0]  vgain_reg, vgain_next;

    csf_pkg::csf_lane_ctrl_t  coil_ctrl;
    csf_pkg::csf_lane_ctrl_t  bus_ctrl;
    csf_pkg::csf_merge_ctrl_t merge_ctrl;
    logic                     cal_busy;
    logic                     out_free;

    logic [csf_pkg::CHANNELS-1:0][csf_pkg::SAMPLE_BITS-1:0] coil_sample;
    logic [csf_pkg::CHANNELS-1:0][csf_pkg::OUT_BITS-1:0]    coil_ma;
    logic [csf_pkg::OUT_BITS-1:0]                           bus_mv;

    always_comb
    begin
        alpha_next = alpha_reg;
        cgain_next = cgain_reg;
        vgain_next = vgain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                csf_pkg::REG_ALPHA:        alpha_next = cfg_data[csf_pkg::ALPHA_BITS-1:0];
                csf_pkg::REG_CURRENT_GAIN: cgain_next = cfg_data;
                csf_pkg::REG_VOLTAGE_GAIN: vgain_next = cfg_data;
                default:                   alpha_next = alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= csf_pkg::ALPHA_RESET;
            cgain_reg <= csf_pkg::GAIN_RESET;
            vgain_reg <= csf_pkg::GAIN_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
            cgain_reg <= cgain_next;
            vgain_reg <= vgain_next;
        end
    end

    assign coil_sample[0] = scan.coil_sample_0;
    assign coil_sample[1] = scan.coil_sample_1;
    assign coil_sample[2] = scan.coil_sample_2;
    assign coil_sample[3] = scan.coil_sample_3;
    assign out_free       = !result_valid || result_ready;

    csf_ctrl #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .mode       (scan.mode),
        .out_free   (out_free),
        .scan_ready (scan_ready),
        .coil_ctrl  (coil_ctrl),
        .bus_ctrl   (bus_ctrl),
        .merge_ctrl (merge_ctrl),
        .cal_busy   (cal_busy)
    );

    for (genvar g = 0; g < csf_pkg::CHANNELS; g++)
    begin : g_coil
        csf_lane #(
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (coil_ctrl),
            .sample (coil_sample[g]),
            .alpha  (alpha_reg),
            .gain   (cgain_reg),
            .scaled (coil_ma[g])
        );
    end

    csf_lane #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_bus_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (bus_ctrl),
        .sample (scan.bus_sample),
        .alpha  (alpha_reg),
        .gain   (vgain_reg),
        .scaled (bus_mv)
    );

    csf_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (merge_ctrl),
        .coil_ma      (coil_ma),
        .bus_mv       (bus_mv),
        .cal_busy     (cal_busy),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    // one scan in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && scan_ready |=> !scan_ready)
        else $error("scan taken while another is in flight");

    // a fresh result is loaded only on the way back to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> scan_ready)
        else $error("result loaded outside the output step");

    a_power: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.power_uw ==
            csf_pkg::POWER_BITS'(result.bus_mv) *
            (csf_pkg::POWER_BITS'(result.current_ma_0) +
             csf_pkg::POWER_BITS'(result.current_ma_1) +
             csf_pkg::POWER_BITS'(result.current_ma_2) +
             csf_pkg::POWER_BITS'(result.current_ma_3)))
        else $error("power does not match the merged lane results");

endmodule
